// ===== rtl/peak_detect_power_energy_meter_core_defines.svh =====
// Assertion macros shared by the meter's sequencer and datapath.
// Depends on a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef PEAK_DETECT_POWER_ENERGY_METER_CORE_DEFINES_SVH
`define PEAK_DETECT_POWER_ENERGY_METER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PDPEM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdpem: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define PDPEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdpem: next-cycle check failed");
`else
`define PDPEM_ASSERT_IMPL(label, ante, cons)
`define PDPEM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/pdpem_pkg.sv =====
// Types, constants and the microprogram of the peak-detect energy meter.
// No dependencies; every other file but the macro header imports this package.
`timescale 1ns / 1ps

package pdpem_pkg;

  // Field widths
  localparam int PHASE_W   = 2;
  localparam int SAMPLE_W  = 16;
  localparam int MS_W      = 16;
  localparam int LEVEL_W   = 15;
  localparam int GAIN_W    = 18;
  localparam int VOLT_W    = 9;
  localparam int CUR_W     = 17;
  localparam int PWR_W     = 26;
  localparam int ENERGY_W  = 63;
  localparam int MUL_A_W   = 26;
  localparam int MUL_B_W   = 18;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int GAIN_FRAC = 16;
  localparam int PHASE_CODES = 1 << PHASE_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE  = 3'd4;

  // Register reset values (gain is 0.707 / 441.19 * 1000 in Q16)
  localparam logic [LEVEL_W-1:0] OFFSET_RST  = 15'd8912;
  localparam logic [GAIN_W-1:0]  GAIN_RST    = 18'd105020;
  localparam logic [VOLT_W-1:0]  VOLTAGE_RST = 9'd230;

  // Saturation limits
  localparam logic [CUR_W-1:0]    CURRENT_MAX = '1;
  localparam logic [PWR_W-1:0]    POWER_MAX   = '1;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX  = '1;

  typedef struct packed {
    logic [LEVEL_W-1:0] offset_a;
    logic [LEVEL_W-1:0] offset_b;
    logic [LEVEL_W-1:0] offset_c;
    logic [GAIN_W-1:0]  gain;
    logic [VOLT_W-1:0]  voltage;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]         phase;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       window_end;
    logic [MS_W-1:0]            elapsed_ms;
  } in_item_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_PEAK,
    OP_MUL_GAIN,
    OP_MUL_VOLT,
    OP_MUL_MS,
    OP_ACCUM
  } op_t;

  // Step-counter jump conditions
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_END_CHECK,
    JC_WAIT_OUT,
    JC_JUMP
  } jc_t;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_FETCH = 3'd0;
  localparam step_t STEP_PEAK  = 3'd1;
  localparam step_t STEP_MUL1  = 3'd2;
  localparam step_t STEP_MUL2  = 3'd3;
  localparam step_t STEP_MUL3  = 3'd4;
  localparam step_t STEP_ACCUM = 3'd5;
  localparam step_t STEP_LAST  = STEP_ACCUM;

  typedef struct packed {
    logic  in_ready;
    op_t   op;
    jc_t   jc;
    step_t target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic go;
    logic in_ready;
    op_t  op;
  } ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic skip;
    logic out_busy;
  } stat_t;

  // Microprogram ROM: one control word per step
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    w = '{in_ready: 1'b0, op: OP_NONE, jc: JC_JUMP, target: STEP_FETCH};
    case (s)
      STEP_FETCH: w = '{in_ready: 1'b1, op: OP_LATCH,    jc: JC_WAIT_IN,   target: STEP_FETCH};
      STEP_PEAK:  w = '{in_ready: 1'b0, op: OP_PEAK,     jc: JC_END_CHECK, target: STEP_FETCH};
      STEP_MUL1:  w = '{in_ready: 1'b0, op: OP_MUL_GAIN, jc: JC_NEXT,      target: STEP_FETCH};
      STEP_MUL2:  w = '{in_ready: 1'b0, op: OP_MUL_VOLT, jc: JC_NEXT,      target: STEP_FETCH};
      STEP_MUL3:  w = '{in_ready: 1'b0, op: OP_MUL_MS,   jc: JC_NEXT,      target: STEP_FETCH};
      STEP_ACCUM: w = '{in_ready: 1'b0, op: OP_ACCUM,    jc: JC_WAIT_OUT,  target: STEP_FETCH};
      default:    w = '{in_ready: 1'b0, op: OP_NONE,     jc: JC_JUMP,      target: STEP_FETCH};
    endcase
    return w;
  endfunction

  // Current from the gain product, saturating
  function automatic logic [CUR_W-1:0] sat_current(input logic [PROD_W-1:0] p);
    logic [CUR_W-1:0] r;
    if (|p[PROD_W-1:GAIN_FRAC+CUR_W]) r = CURRENT_MAX;
    else r = p[GAIN_FRAC+CUR_W-1:GAIN_FRAC];
    return r;
  endfunction

  // Power from the voltage product, saturating
  function automatic logic [PWR_W-1:0] sat_power(input logic [PROD_W-1:0] p);
    logic [PWR_W-1:0] r;
    if (|p[PROD_W-1:PWR_W]) r = POWER_MAX;
    else r = p[PWR_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/pdpem_in_if.sv =====
// Sample channel of the energy meter: valid/ready plus one converter sample.
// Depends on pdpem_pkg for field widths.
`timescale 1ns / 1ps

interface pdpem_in_if;
  import pdpem_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [PHASE_W-1:0]         phase;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       window_end;
  logic [MS_W-1:0]            elapsed_ms;

  modport source (output valid, phase, sample, window_end, elapsed_ms, input ready);
  modport sink   (input valid, phase, sample, window_end, elapsed_ms, output ready);
endinterface

// ===== rtl/pdpem_out_if.sv =====
// Reading channel of the energy meter: valid/ready plus one window result.
// Depends on pdpem_pkg for field widths.
`timescale 1ns / 1ps

interface pdpem_out_if;
  import pdpem_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PHASE_W-1:0]    out_phase;
  logic [LEVEL_W-1:0]    peak_level;
  logic [CUR_W-1:0]      current_ma;
  logic [PWR_W-1:0]      power_mw;
  logic [PWR_W-1:0]      max_power_mw;
  logic [ENERGY_W-1:0]   energy_uj;

  modport source (output valid, out_phase, peak_level, current_ma, power_mw, max_power_mw,
                  energy_uj, input ready);
  modport sink   (input valid, out_phase, peak_level, current_ma, power_mw, max_power_mw,
                  energy_uj, output ready);
endinterface

// ===== rtl/pdpem_cfg_if.sv =====
// Register write channel of the energy meter: valid/ready, index and data.
// Depends on pdpem_pkg for field widths.
`timescale 1ns / 1ps

interface pdpem_cfg_if;
  import pdpem_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/peak_detect_power_energy_meter_core.sv =====
// Top level of the three-phase peak-detect energy meter.
// Depends on pdpem_pkg, the three channel interfaces, pdpem_cfg, pdpem_seq, pdpem_dp.
//
// Channels: samples (sink) takes one converter sample per beat, tagged with a
// phase, a window-end flag and the elapsed milliseconds. readings (source)
// gives one beat per window end: phase, clamped peak, current in mA, power in
// mW, peak power and the saturating energy total in uJ. cfg (sink) writes the
// three phase offsets, the Q16 current gain and the line voltage; it is always
// ready and a write to an unknown index is dropped.
// Timing: a microprogram of six steps drives a datapath with one shared
// 26x18 multiplier. A sample that does not end a window runs the fetch and
// peak steps only; a window-end sample runs all six steps, with its
// reading valid on the cycle after the last step. Samples of phases that are
// not present also return after the peak step and change nothing.
// Reset: the registers take their default values and all per-phase peaks,
// peak powers and energy totals clear at once; no clearing pass is needed.
// Stall: a finished reading waits in the output register while the next
// samples are accepted; the program holds on its last step only when a new
// reading is ready and the previous one has not been taken.
`timescale 1ns / 1ps

module peak_detect_power_energy_meter_core #(
  parameter int NUM_PHASES = 3
) (
  input  logic         clk,
  input  logic         rst,
  pdpem_in_if.sink     samples,
  pdpem_out_if.source  readings,
  pdpem_cfg_if.sink    cfg
);
  import pdpem_pkg::*;

  cfg_t     cfg_regs;
  ctl_t     ctl;
  stat_t    stat;
  in_item_t item;

  // Gather the sample beat and hand ready back from the sequencer
  assign item.phase      = samples.phase;
  assign item.sample     = samples.sample;
  assign item.window_end = samples.window_end;
  assign item.elapsed_ms = samples.elapsed_ms;
  assign samples.ready   = ctl.in_ready;

  pdpem_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  pdpem_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  pdpem_dp #(
    .NUM_PHASES (NUM_PHASES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .item     (item),
    .ctl      (ctl),
    .stat     (stat),
    .readings (readings)
  );

endmodule

// ===== rtl/pdpem_cfg.sv =====
// Configuration register file of the energy meter.
// Depends on pdpem_pkg and pdpem_cfg_if.
`timescale 1ns / 1ps

module pdpem_cfg (
  input  logic             clk,
  input  logic             rst,
  pdpem_cfg_if.sink        cfg,
  output pdpem_pkg::cfg_t  regs
);
  import pdpem_pkg::*;

  // Always take a write beat
  assign cfg.ready = 1'b1;

  // Decode the index and hold the register; unknown indexes drop the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.offset_a <= OFFSET_RST;
      regs.offset_b <= OFFSET_RST;
      regs.offset_c <= OFFSET_RST;
      regs.gain     <= GAIN_RST;
      regs.voltage  <= VOLTAGE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OFFSET_A: regs.offset_a <= cfg.data[LEVEL_W-1:0];
        REG_OFFSET_B: regs.offset_b <= cfg.data[LEVEL_W-1:0];
        REG_OFFSET_C: regs.offset_c <= cfg.data[LEVEL_W-1:0];
        REG_GAIN:     regs.gain     <= cfg.data[GAIN_W-1:0];
        REG_VOLTAGE:  regs.voltage  <= cfg.data[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pdpem_seq.sv =====
// Microcoded sequencer: step counter, control-word ROM and jump logic.
// Depends on pdpem_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "peak_detect_power_energy_meter_core_defines.svh"

module pdpem_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  pdpem_pkg::stat_t stat,
  output pdpem_pkg::ctl_t  ctl
);
  import pdpem_pkg::*;

  step_t  step;
  step_t  step_next;
  step_t  step_inc;
  uword_t uw;
  logic   go;

  // Fetch the control word of the current step
  assign uw       = ucode_rom(step);
  assign step_inc = step_t'(step + 1'b1);

  // Resolve the jump condition
  always_comb begin
    go        = 1'b1;
    step_next = step_inc;
    case (uw.jc)
      JC_NEXT: begin
        step_next = step_inc;
      end
      JC_WAIT_IN: begin
        go        = in_valid & uw.in_ready;
        step_next = go ? step_inc : step;
      end
      JC_END_CHECK: begin
        step_next = stat.skip ? uw.target : step_inc;
      end
      JC_WAIT_OUT: begin
        go        = !stat.out_busy;
        step_next = go ? uw.target : step;
      end
      JC_JUMP: begin
        step_next = uw.target;
      end
      default: begin
        step_next = STEP_FETCH;
      end
    endcase
  end

  assign ctl.go       = go;
  assign ctl.in_ready = uw.in_ready;
  assign ctl.op       = uw.op;

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

  `PDPEM_ASSERT_NEXT(a_accept_to_peak, ctl.go && ctl.op == OP_LATCH, step == STEP_PEAK)
  `PDPEM_ASSERT_IMPL(a_step_in_program, 1'b1, step <= STEP_LAST)
  `PDPEM_ASSERT_NEXT(a_skip_returns, step == STEP_PEAK && stat.skip, step == STEP_FETCH)

endmodule

// ===== rtl/pdpem_dp.sv =====
// Datapath of the energy meter: per-phase state, shared multiplier, output register.
// Depends on pdpem_pkg, pdpem_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "peak_detect_power_energy_meter_core_defines.svh"

module pdpem_dp #(
  parameter int NUM_PHASES = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  pdpem_pkg::cfg_t     cfg,
  input  pdpem_pkg::in_item_t item,
  input  pdpem_pkg::ctl_t     ctl,
  output pdpem_pkg::stat_t    stat,
  pdpem_out_if.source         readings
);
  import pdpem_pkg::*;

  // Only phases that the phase field can name need storage
  localparam int SLOTS = (NUM_PHASES < PHASE_CODES) ? NUM_PHASES : PHASE_CODES;

  // Latched sample
  logic [PHASE_W-1:0]         ph;
  logic signed [SAMPLE_W-1:0] smp;
  logic                       last;
  logic [MS_W-1:0]            ms;

  // Per-phase state
  logic [LEVEL_W-1:0]  window_peak  [SLOTS];
  logic [PWR_W-1:0]    peak_power   [SLOTS];
  logic [ENERGY_W-1:0] energy_total [SLOTS];

  // Working registers
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] excess;
  logic [PROD_W-1:0]  prod;
  logic [CUR_W-1:0]   cur;
  logic [PWR_W-1:0]   pwr;
  logic [PWR_W-1:0]   max_pwr;

  // Output register
  logic                o_valid;
  logic [PHASE_W-1:0]  o_phase;
  logic [LEVEL_W-1:0]  o_level;
  logic [CUR_W-1:0]    o_cur;
  logic [PWR_W-1:0]    o_pwr;
  logic [PWR_W-1:0]    o_max;
  logic [ENERGY_W-1:0] o_energy;

  logic                phase_ok;
  logic [LEVEL_W-1:0]  offset;
  logic [LEVEL_W-1:0]  cand;
  logic [LEVEL_W-1:0]  clamped;
  logic [CUR_W-1:0]    cur_n;
  logic [PWR_W-1:0]    pwr_n;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod_next;
  logic [ENERGY_W:0]   sum;
  logic [ENERGY_W-1:0] energy_n;
  logic                load_out;

  assign phase_ok = int'(ph) < NUM_PHASES;

  // Pick the zero offset; phases past the third share the last one
  always_comb begin
    case (ph)
      2'd0:    offset = cfg.offset_a;
      2'd1:    offset = cfg.offset_b;
      default: offset = cfg.offset_c;
    endcase
  end

  // Running peak with this sample, then clamp to the offset
  assign cand    = (!smp[SAMPLE_W-1] && smp[LEVEL_W-1:0] >= window_peak[ph]) ?
                   smp[LEVEL_W-1:0] : window_peak[ph];
  assign clamped = (cand <= offset) ? offset : cand;

  // Saturate the previous product before it feeds the multiplier again
  assign cur_n = sat_current(prod);
  assign pwr_n = sat_power(prod);

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      OP_MUL_GAIN: begin
        mul_a = MUL_A_W'(excess);
        mul_b = cfg.gain;
      end
      OP_MUL_VOLT: begin
        mul_a = MUL_A_W'(cur_n);
        mul_b = MUL_B_W'(cfg.voltage);
      end
      OP_MUL_MS: begin
        mul_a = pwr_n;
        mul_b = MUL_B_W'(ms);
      end
      default: ;
    endcase
  end

  assign prod_next = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // Saturating energy add; the top bit of the sum flags overflow
  assign sum      = {1'b0, energy_total[ph]} + (ENERGY_W+1)'(prod);
  assign energy_n = sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];

  assign load_out = ctl.go && ctl.op == OP_ACCUM;

  // Hold per-phase state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        window_peak[i]  <= '0;
        peak_power[i]   <= '0;
        energy_total[i] <= '0;
      end
      o_valid <= 1'b0;
    end else begin
      if (load_out) o_valid <= 1'b1;
      else if (readings.ready) o_valid <= 1'b0;
      if (ctl.go) begin
        case (ctl.op)
          OP_PEAK: begin
            if (phase_ok) window_peak[ph] <= last ? '0 : cand;
          end
          OP_MUL_MS: begin
            if (pwr_n > peak_power[ph]) peak_power[ph] <= pwr_n;
          end
          OP_ACCUM: begin
            energy_total[ph] <= energy_n;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      case (ctl.op)
        OP_LATCH: begin
          ph   <= item.phase;
          smp  <= item.sample;
          last <= item.window_end;
          ms   <= item.elapsed_ms;
        end
        OP_PEAK: begin
          level  <= clamped;
          excess <= clamped - offset;
        end
        OP_MUL_GAIN: begin
          prod <= prod_next;
        end
        OP_MUL_VOLT: begin
          prod <= prod_next;
          cur  <= cur_n;
        end
        OP_MUL_MS: begin
          prod    <= prod_next;
          pwr     <= pwr_n;
          max_pwr <= (pwr_n > peak_power[ph]) ? pwr_n : peak_power[ph];
        end
        OP_ACCUM: begin
          o_phase  <= ph;
          o_level  <= level;
          o_cur    <= cur;
          o_pwr    <= pwr;
          o_max    <= max_pwr;
          o_energy <= energy_n;
        end
        default: ;
      endcase
    end
  end

  assign stat.skip     = !phase_ok || !last;
  assign stat.out_busy = o_valid && !readings.ready;

  assign readings.valid        = o_valid;
  assign readings.out_phase    = o_phase;
  assign readings.peak_level   = o_level;
  assign readings.current_ma   = o_cur;
  assign readings.power_mw     = o_pwr;
  assign readings.max_power_mw = o_max;
  assign readings.energy_uj    = o_energy;

  `PDPEM_ASSERT_NEXT(a_load_sets_valid, load_out, o_valid)
  `PDPEM_ASSERT_IMPL(a_no_load_over_busy, load_out, !stat.out_busy)
  `PDPEM_ASSERT_IMPL(a_max_covers_power, o_valid, o_max >= o_pwr)

endmodule
